// ===== sv/scs_pkg.sv =====
// Shared types, codes and constants for the scrolling seven-segment scanner.
// Used by the controller, the datapath and the top level; depends on nothing.
package scs_pkg;

    localparam int DIGITS = 4;
    // Width of a logical byte position: an 8-bit frame position plus a digit offset.
    localparam int POS_W = 9;

    typedef logic [1:0] t_kind;
    localparam t_kind KIND_TICK  = 2'd0;
    localparam t_kind KIND_PUSH  = 2'd1;
    localparam t_kind KIND_CLEAR = 2'd2;

    typedef logic [2:0] t_mode;
    localparam t_mode MODE_LOOP_ONE      = 3'd0;
    localparam t_mode MODE_LOOP_FOUR     = 3'd1;
    localparam t_mode MODE_CONSUME_ONE   = 3'd2;
    localparam t_mode MODE_CONSUME_FOUR  = 3'd3;
    localparam t_mode MODE_HOLD          = 3'd4;

    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_DISPLAY_MODE = 2'd0;
    localparam t_cfg_idx CFG_FRAME_REPEAT = 2'd1;

    localparam logic [7:0] FRAME_REPEAT_RESET = 8'd1;
    localparam logic [7:0] DIGIT_RESET        = 8'hFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_LAST,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic accept;
        logic exec;
        logic rd_issue;
        logic finish;
        logic emit;
    } t_ctrl_cmd;

    typedef struct packed {
        logic load_go;
        logic rd_last;
        logic out_free;
    } t_ctrl_sts;

    // Active-low digit select pattern for a scan position.
    function automatic logic [7:0] select_code(input logic [1:0] pos);
        logic [7:0] code;
        case (pos)
            2'd0: code = 8'hEE;
            2'd1: code = 8'hDD;
            2'd2: code = 8'hBB;
            default: code = 8'h77;
        endcase
        return code;
    endfunction

endpackage

// ===== sv/scs_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package dependencies.
module scs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/scs_ctrl.sv =====
// Sequencing state machine of the scanner: accept, execute, frame read, result.
// Depends on scs_pkg for the state type and the command and status structs.
module scs_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  scs_pkg::t_ctrl_sts  i_sts,
    output logic                o_in_stall,
    output scs_pkg::t_ctrl_cmd  o_cmd
);

    scs_pkg::t_state r_state;
    scs_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= scs_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            scs_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = scs_pkg::ST_EXEC;
                end
            end
            scs_pkg::ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_sts.load_go ? scs_pkg::ST_READ : scs_pkg::ST_EMIT;
            end
            scs_pkg::ST_READ: begin
                o_cmd.rd_issue = 1'b1;
                if (i_sts.rd_last) begin
                    n_state = scs_pkg::ST_LAST;
                end
            end
            scs_pkg::ST_LAST: begin
                o_cmd.finish = 1'b1;
                n_state      = scs_pkg::ST_EMIT;
            end
            scs_pkg::ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = scs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = scs_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/scs_dp.sv =====
// Datapath of the scanner: scan and frame state, cache pointers, digit registers,
// frame cache RAM and the result register. Depends on scs_pkg and scs_ram.
module scs_dp #(
    parameter int CACHE_DEPTH = 128
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  scs_pkg::t_ctrl_cmd  i_cmd,
    output scs_pkg::t_ctrl_sts  o_sts,
    input  logic [1:0]          i_kind,
    input  logic [7:0]          i_data_byte,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [7:0]          i_cfg_data,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output logic [7:0]          o_digit_select,
    output logic [7:0]          o_segments,
    output logic [7:0]          o_cache_level,
    output logic                o_push_dropped
);

    localparam int AW = $clog2(CACHE_DEPTH);
    localparam int FW = $clog2(CACHE_DEPTH + 1);
    localparam int PW = scs_pkg::POS_W;
    localparam logic [AW:0]   DEPTH_A = (AW + 1)'(CACHE_DEPTH);
    localparam logic [FW-1:0] DEPTH_F = FW'(CACHE_DEPTH);

    // Item and configuration state.
    scs_pkg::t_kind r_kind;
    logic [7:0]     r_data;
    scs_pkg::t_mode r_mode;
    logic [7:0]     r_frame_repeat;
    logic [1:0]     r_scan;
    logic [7:0]     r_repeat;
    logic [7:0]     r_index;
    logic [7:0]     r_offset;
    logic [7:0]     r_total;
    logic [FW-1:0]  r_fill;
    logic [AW-1:0]  r_head;
    logic [7:0]     r_digit [scs_pkg::DIGITS];

    // Frame read sequencing.
    logic [7:0]     r_base;
    logic [1:0]     r_j;
    logic           r_cap_pend;
    logic [1:0]     r_cap_j;
    logic           r_cap_ok;

    // Staged result and output register.
    logic [7:0]     r_res_sel;
    logic [7:0]     r_res_seg;
    logic           r_res_drop;
    logic           r_out_valid;
    logic [7:0]     r_out_sel;
    logic [7:0]     r_out_seg;
    logic [7:0]     r_out_level;
    logic           r_out_drop;

    logic [1:0]     sp_n;
    logic           scan_wrap;
    logic [7:0]     rc_inc;
    logic           is_loop;
    logic           is_consume;
    logic           do_load;
    logic           frame_wrap;
    logic [7:0]     idx_w;
    logic [7:0]     off_w;
    logic [1:0]     res_pos;

    logic [PW-1:0]  p_raw;
    logic [PW-1:0]  p_total;
    logic [PW-1:0]  p_pos;
    logic           p_ok;
    logic [AW:0]    rd_sum;
    logic [AW-1:0]  rd_addr;
    logic [AW:0]    wr_sum;
    logic [AW-1:0]  wr_addr;
    logic           push_ok;
    logic           mem_we;
    logic [7:0]     mem_rdata;
    logic [FW-1:0]  step_f;
    logic [AW:0]    head_sum;
    logic [AW-1:0]  head_next;
    scs_pkg::t_mode cfg_mode;

    // Decode of the item being executed.
    always_comb begin
        sp_n       = r_scan + 2'd1;
        scan_wrap  = (sp_n == 2'd0);
        rc_inc     = r_repeat + 8'd1;
        is_loop    = r_mode inside {scs_pkg::MODE_LOOP_ONE, scs_pkg::MODE_LOOP_FOUR};
        is_consume = r_mode inside {scs_pkg::MODE_CONSUME_ONE, scs_pkg::MODE_CONSUME_FOUR};
        do_load    = (r_kind == scs_pkg::KIND_TICK) && scan_wrap
                  && (rc_inc == r_frame_repeat) && (is_loop || is_consume);
        frame_wrap = (r_index == r_total);
        idx_w      = frame_wrap ? 8'd0 : r_index;
        off_w      = frame_wrap ? 8'd0 : r_offset;
        res_pos    = (r_kind == scs_pkg::KIND_TICK) ? sp_n : r_scan;
        push_ok    = (r_fill < DEPTH_F);
        cfg_mode   = i_cfg_data[2:0];
    end

    // Logical byte position of the current frame read and its cache address.
    always_comb begin
        p_raw   = PW'(r_base) + PW'(r_j);
        p_total = PW'(r_total);
        if ((r_mode == scs_pkg::MODE_LOOP_ONE) && (r_total != 8'd0) && (p_raw >= p_total)) begin
            p_pos = p_raw - p_total;
        end else begin
            p_pos = p_raw;
        end
        // Bytes at or past the fill level read as zero.
        p_ok    = (p_pos < PW'(r_fill));
        rd_sum  = (AW + 1)'(r_head) + (AW + 1)'(p_pos);
        rd_addr = (rd_sum >= DEPTH_A) ? AW'(rd_sum - DEPTH_A) : AW'(rd_sum);
        wr_sum  = (AW + 1)'(r_head) + (AW + 1)'(r_fill);
        wr_addr = (wr_sum >= DEPTH_A) ? AW'(wr_sum - DEPTH_A) : AW'(wr_sum);
        step_f  = (r_mode == scs_pkg::MODE_CONSUME_FOUR) ? FW'(4) : FW'(1);
        head_sum  = (AW + 1)'(r_head) + (AW + 1)'(step_f);
        head_next = (head_sum >= DEPTH_A) ? AW'(head_sum - DEPTH_A) : AW'(head_sum);
    end

    assign mem_we = i_cmd.exec && (r_kind == scs_pkg::KIND_PUSH) && push_ok;

    scs_ram #(
        .WIDTH (8),
        .DEPTH (CACHE_DEPTH)
    ) u_cache (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (wr_addr),
        .i_wdata (r_data),
        .i_raddr (rd_addr),
        .o_rdata (mem_rdata)
    );

    // Control and architectural state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= scs_pkg::MODE_HOLD;
            r_frame_repeat <= scs_pkg::FRAME_REPEAT_RESET;
            r_scan         <= '0;
            r_repeat       <= '0;
            r_index        <= '0;
            r_offset       <= '0;
            r_total        <= '0;
            r_fill         <= '0;
            r_head         <= '0;
            r_j            <= '0;
            r_cap_pend     <= 1'b0;
            r_out_valid    <= 1'b0;
            for (int k = 0; k < scs_pkg::DIGITS; k++) begin
                r_digit[k] <= scs_pkg::DIGIT_RESET;
            end
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == scs_pkg::CFG_DISPLAY_MODE) begin
                    r_mode <= cfg_mode;
                    if (cfg_mode inside {scs_pkg::MODE_LOOP_ONE, scs_pkg::MODE_LOOP_FOUR}) begin
                        r_repeat <= '0;
                        r_index  <= '0;
                        r_offset <= '0;
                        r_total  <= (cfg_mode == scs_pkg::MODE_LOOP_FOUR) ? 8'(r_fill >> 2)
                                                                          : 8'(r_fill);
                    end else if (cfg_mode inside {scs_pkg::MODE_CONSUME_ONE,
                                                  scs_pkg::MODE_CONSUME_FOUR}) begin
                        r_repeat <= '0;
                    end
                end else if (i_cfg_index == scs_pkg::CFG_FRAME_REPEAT) begin
                    r_frame_repeat <= i_cfg_data;
                end
            end

            if (i_cmd.exec) begin
                r_j <= '0;
                case (r_kind)
                    scs_pkg::KIND_TICK: begin
                        r_scan <= sp_n;
                        if (scan_wrap) begin
                            r_repeat <= do_load ? 8'd0 : rc_inc;
                        end
                        if (do_load) begin
                            if (is_loop) begin
                                r_index <= idx_w + 8'd1;
                            end else begin
                                r_index <= r_index + 8'd1;
                            end
                            if (r_mode == scs_pkg::MODE_LOOP_FOUR) begin
                                r_offset <= off_w + 8'd4;
                            end else if (r_mode == scs_pkg::MODE_LOOP_ONE) begin
                                r_offset <= idx_w;
                            end
                        end
                    end
                    scs_pkg::KIND_PUSH: begin
                        if (push_ok) begin
                            r_fill <= r_fill + FW'(1);
                        end
                    end
                    scs_pkg::KIND_CLEAR: begin
                        r_fill <= '0;
                    end
                    default: begin
                    end
                endcase
            end

            // One cache read per cycle; the data returns in the cycle after the read.
            if (i_cmd.rd_issue) begin
                r_j        <= r_j + 2'd1;
                r_cap_pend <= 1'b1;
            end else begin
                r_cap_pend <= 1'b0;
            end
            if (r_cap_pend) begin
                r_digit[r_cap_j] <= r_cap_ok ? mem_rdata : 8'd0;
            end

            if (i_cmd.finish && is_consume) begin
                r_head <= head_next;
                r_fill <= (r_fill > step_f) ? (r_fill - step_f) : '0;
            end

            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind <= i_kind;
            r_data <= i_data_byte;
        end
        if (i_cmd.exec) begin
            r_res_sel  <= scs_pkg::select_code(res_pos);
            r_res_seg  <= r_digit[res_pos];
            r_res_drop <= (r_kind == scs_pkg::KIND_PUSH) && !push_ok;
            if (r_mode == scs_pkg::MODE_LOOP_FOUR) begin
                r_base <= off_w;
            end else if (r_mode == scs_pkg::MODE_LOOP_ONE) begin
                r_base <= idx_w;
            end else begin
                r_base <= 8'd0;
            end
        end
        if (i_cmd.rd_issue) begin
            r_cap_j  <= r_j;
            r_cap_ok <= p_ok;
        end
        if (i_cmd.emit) begin
            r_out_sel   <= r_res_sel;
            r_out_seg   <= r_res_seg;
            r_out_level <= 8'(r_fill);
            r_out_drop  <= r_res_drop;
        end
    end

    assign o_sts.load_go  = do_load && (is_loop || (r_fill != '0));
    assign o_sts.rd_last  = (r_j == 2'd3);
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid    = r_out_valid;
    assign o_digit_select = r_out_sel;
    assign o_segments     = r_out_seg;
    assign o_cache_level  = r_out_level;
    assign o_push_dropped = r_out_drop;

endmodule

// ===== sv/scrolling_seven_segment_scanner_unit.sv =====
// Top level of the scrolling seven-segment scanner.
// Depends on scs_pkg, scs_ctrl, scs_dp and, through the datapath, scs_ram.
//
// Usage:
// Items arrive on the input channel (i_in_valid / o_in_stall) with fields i_kind and
// i_data_byte. A scan tick advances the digit scan, a push appends a byte to the frame
// cache and a clear empties it. Every accepted item yields exactly one result
// transaction on the output channel (o_out_valid / i_out_stall) carrying the digit
// select, the segment byte of that digit, the cache level and a dropped-push flag.
// One item is in work at a time. A push, a clear or a tick without a frame load goes
// from acceptance through the execute state to the result state; a tick that loads a
// frame passes through the read and last states in between, where the four frame
// bytes are fetched one per cycle through the single read port of the cache RAM.
// The result register sits between the block and the receiver, so
// while the receiver stalls the block may accept and execute the next item, holding
// its result until the register frees up. The configuration channel (i_cfg_valid /
// o_cfg_ready, always ready) writes display_mode (index 0) and frame_repeat (index 1)
// and must only be used while the block is idle. Reset (synchronous, active low)
// empties the cache, sets all digits to 0xFF, hold mode and a repeat of one.
module scrolling_seven_segment_scanner_unit #(
    parameter int CACHE_DEPTH = 128
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Item channel.
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_kind,
    input  logic [7:0] i_data_byte,
    // Result channel.
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_digit_select,
    output logic [7:0] o_segments,
    output logic [7:0] o_cache_level,
    output logic       o_push_dropped,
    // Configuration write channel.
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    scs_pkg::t_ctrl_cmd cmd;
    scs_pkg::t_ctrl_sts sts;

    // Register writes are applied as they arrive, so the port never pushes back.
    assign o_cfg_ready = 1'b1;

    // The controller walks each item through execute, optional frame read and result.
    scs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    // The datapath holds all display, cache and result state.
    scs_dp #(
        .CACHE_DEPTH (CACHE_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_kind         (i_kind),
        .i_data_byte    (i_data_byte),
        .i_cfg_we       (i_cfg_valid && o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_digit_select (o_digit_select),
        .o_segments     (o_segments),
        .o_cache_level  (o_cache_level),
        .o_push_dropped (o_push_dropped)
    );

endmodule

// ===== sv/scs_checker.sv =====
// Port-level checks for the scrolling seven-segment scanner, bound to its top level.
// Depends only on the top-level ports.
module scs_checker #(
    parameter int CACHE_DEPTH = 128
) (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_digit_select,
    input logic [7:0] o_segments,
    input logic [7:0] o_cache_level,
    input logic       o_push_dropped
);

    // A waiting result keeps its contents while the receiver stalls.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_digit_select)
            && $stable(o_segments) && $stable(o_cache_level) && $stable(o_push_dropped))
        else $error("result changed while stalled");

    // A valid result always carries one of the four scan select codes.
    a_select_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_digit_select == 8'hEE) || (o_digit_select == 8'hDD)
            || (o_digit_select == 8'hBB) || (o_digit_select == 8'h77))
        else $error("illegal digit select");

    // A push is only dropped when the cache is full.
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_push_dropped |-> o_cache_level == 8'(CACHE_DEPTH))
        else $error("push dropped with cache not full");

    // Items are worked one at a time, so an accept is never followed straight away by another.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("back-to-back accept");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind scrolling_seven_segment_scanner_unit scs_checker #(
    .CACHE_DEPTH (CACHE_DEPTH)
) u_scs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_digit_select (o_digit_select),
    .o_segments     (o_segments),
    .o_cache_level  (o_cache_level),
    .o_push_dropped (o_push_dropped)
);
